/* rtl/core/motor_speed_pi_regulator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the motor speed PI regulator
// Concurrent checks on the rising clock edge, off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_PI_REGULATOR_UNIT_ASSERT_SVH
`define MOTOR_SPEED_PI_REGULATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define MSPI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mspi: same-cycle check failed");
// next-cycle implication
`define MSPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mspi: next-cycle check failed");
`else
`define MSPI_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MSPI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/mspi_pkg.sv */
// ----------------------------------------------------------------------------
// mspi_pkg
// Types and constants shared by the motor speed PI regulator modules.
// ----------------------------------------------------------------------------
package mspi_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;

	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_REF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_C     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT = 3'd5;

	localparam logic [7:0]  RST_SPEED_REF  = 8'd50;
	localparam logic [17:0] RST_SPEED_NUM  = 18'd209440;
	localparam logic [23:0] RST_GAIN_B     = 24'd44493;
	localparam logic [25:0] RST_GAIN_C     = 26'd17528907;
	localparam logic [25:0] RST_GAIN_D     = 26'd42617;
	localparam logic [15:0] RST_DUTY_LIMIT = 16'd1000;

	// quotient bits produced by the serial divider, one per cycle
	localparam int DIV_STEPS = 18;
	localparam int DIV_CNT_W = 5;

	typedef struct packed {
		logic                  valid;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} mspi_cfg_wr_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic calc_err;
		logic mul_lo;
		logic mul_hi;
		logic mul_d;
		logic mul_b;
		logic sum;
		logic finish;
	} mspi_cmd_t;

	typedef struct packed {
		logic div_last;
	} mspi_stat_t;

endpackage

/* rtl/core/mspi_datapath.sv */
// ----------------------------------------------------------------------------
// mspi_datapath
// Register file, serial speed divider, shared multiplier, PI sums, integrator
// and result register.
// ----------------------------------------------------------------------------
module mspi_datapath import mspi_pkg::*; #(
	parameter int DUTY_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  mspi_cfg_wr_t cfg_wr,
	input  mspi_cmd_t    cmd,
	output mspi_stat_t   stat,
	input  logic [15:0]  capture_period,
	input  logic         running,
	output logic [15:0]  duty,
	output logic [7:0]   measured_speed,
	output logic [7:0]   speed_error
);

	localparam logic [24:0] DUTY_CAP = 25'((1 << DUTY_WIDTH) - 1);

	logic [7:0]  speed_ref_q;
	logic [17:0] speed_num_q;
	logic [23:0] gain_b_q;
	logic [25:0] gain_c_q;
	logic [25:0] gain_d_q;
	logic [15:0] duty_limit_q;

	logic signed [47:0] integ_q;

	logic [15:0]          per_q;
	logic                 run_q;
	logic [15:0]          rem_q;
	logic [17:0]          quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [7:0]  speed_q;
	logic [7:0]  err_q;
	logic        e_neg_q;
	logic [7:0]  e_mag_q;
	logic [47:0] mag_q;
	logic        c_neg_q;

	logic [25:0] mul_a;
	logic [23:0] mul_b;
	logic [49:0] prod_q;

	logic signed [52:0] acc_q;
	logic signed [34:0] dterm_q;
	logic signed [32:0] bterm_q;

	logic [15:0] duty_q;
	logic [7:0]  speed_out_q;
	logic [7:0]  err_out_q;

	logic [16:0] rem_sh;
	logic        rem_ge;
	logic [16:0] rem_nx;
	logic [7:0]  speed_nx;
	logic [7:0]  err_nx;
	logic [15:0] duty_max;
	logic [36:0] duty_raw;
	logic [15:0] duty_nx;
	logic signed [48:0] integ_sum;
	logic signed [47:0] integ_nx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_ref_q  <= RST_SPEED_REF;
			speed_num_q  <= RST_SPEED_NUM;
			gain_b_q     <= RST_GAIN_B;
			gain_c_q     <= RST_GAIN_C;
			gain_d_q     <= RST_GAIN_D;
			duty_limit_q <= RST_DUTY_LIMIT;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				CFG_SPEED_REF:  speed_ref_q  <= cfg_wr.data[7:0];
				CFG_SPEED_NUM:  speed_num_q  <= cfg_wr.data[17:0];
				CFG_GAIN_B:     gain_b_q     <= cfg_wr.data[23:0];
				CFG_GAIN_C:     gain_c_q     <= cfg_wr.data[25:0];
				CFG_GAIN_D:     gain_d_q     <= cfg_wr.data[25:0];
				CFG_DUTY_LIMIT: duty_limit_q <= cfg_wr.data[15:0];
				default: ;
			endcase
		end
	end

	// restoring divider step
	assign rem_sh = {rem_q, quo_q[17]};
	assign rem_ge = rem_sh >= {1'b0, per_q};
	assign rem_nx = rem_ge ? rem_sh - {1'b0, per_q} : rem_sh;

	assign stat.div_last = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	assign speed_nx = (run_q && per_q != '0) ? quo_q[7:0] : 8'd0;
	assign err_nx   = speed_ref_q - speed_nx;

	// shared unsigned multiplier, operands picked by phase
	always_comb begin
		mul_a = gain_c_q;
		mul_b = mag_q[23:0];
		if (cmd.mul_hi) begin
			mul_b = mag_q[47:24];
		end else if (cmd.mul_d) begin
			mul_a = gain_d_q;
			mul_b = {16'd0, e_mag_q};
		end else if (cmd.mul_b) begin
			mul_a = {2'b00, gain_b_q};
			mul_b = {16'd0, e_mag_q};
		end
	end

	// duty clamp
	assign duty_max = ({9'd0, duty_limit_q} < DUTY_CAP) ? duty_limit_q : DUTY_CAP[15:0];
	assign duty_raw = acc_q[52:16];
	always_comb begin
		if (acc_q[52]) begin
			duty_nx = 16'd0;
		end else if (duty_raw > {21'd0, duty_max}) begin
			duty_nx = duty_max;
		end else begin
			duty_nx = duty_raw[15:0];
		end
	end

	// integrator update with saturation
	assign integ_sum = $signed({integ_q[47], integ_q}) + $signed({{16{bterm_q[32]}}, bterm_q});
	always_comb begin
		if (integ_sum[48:47] == 2'b01) begin
			integ_nx = {1'b0, {47{1'b1}}};
		end else if (integ_sum[48:47] == 2'b10) begin
			integ_nx = {1'b1, {47{1'b0}}};
		end else begin
			integ_nx = integ_sum[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (cmd.finish) begin
			integ_q <= integ_nx;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			per_q <= capture_period;
			run_q <= running;
			rem_q <= '0;
			quo_q <= speed_num_q;
		end
		if (cmd.div_step) begin
			rem_q <= rem_nx[15:0];
			quo_q <= {quo_q[16:0], rem_ge};
		end
		if (cmd.calc_err) begin
			speed_q <= speed_nx;
			err_q   <= err_nx;
			e_neg_q <= err_nx[7];
			e_mag_q <= err_nx[7] ? 8'd0 - err_nx : err_nx;
			c_neg_q <= integ_q[47];
			mag_q   <= integ_q[47] ? 48'd0 - integ_q : integ_q;
		end
		if (cmd.mul_lo || cmd.mul_hi || cmd.mul_d || cmd.mul_b) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.mul_hi) begin
			// low partial product contributes only from bit 24 up
			acc_q <= $signed({27'd0, prod_q[49:24]});
		end
		if (cmd.mul_d) begin
			acc_q <= acc_q + $signed({3'd0, prod_q});
		end
		if (cmd.mul_b) begin
			acc_q   <= c_neg_q ? -acc_q : acc_q;
			dterm_q <= e_neg_q ? -$signed({1'b0, prod_q[33:0]}) : $signed({1'b0, prod_q[33:0]});
		end
		if (cmd.sum) begin
			acc_q   <= acc_q + $signed({{18{dterm_q[34]}}, dterm_q});
			bterm_q <= e_neg_q ? -$signed({2'b00, prod_q[30:0]}) : $signed({2'b00, prod_q[30:0]});
		end
		if (cmd.finish) begin
			duty_q      <= duty_nx;
			speed_out_q <= speed_q;
			err_out_q   <= err_q;
		end
	end

	assign duty           = duty_q;
	assign measured_speed = speed_out_q;
	assign speed_error    = err_out_q;

endmodule

/* rtl/core/mspi_ctrl.sv */
// ----------------------------------------------------------------------------
// mspi_ctrl
// Sequencer for one control tick: accept, divide, error, multiply, sum, emit.
// ----------------------------------------------------------------------------
module mspi_ctrl import mspi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  mspi_stat_t stat,
	output mspi_cmd_t  cmd
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DIV  = 9'b000000010,
		ST_ERR  = 9'b000000100,
		ST_MLO  = 9'b000001000,
		ST_MHI  = 9'b000010000,
		ST_MD   = 9'b000100000,
		ST_MB   = 9'b001000000,
		ST_SUM  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nx = ST_ERR;
				end
			end
			ST_ERR: begin
				cmd.calc_err = 1'b1;
				state_nx     = ST_MLO;
			end
			ST_MLO: begin
				cmd.mul_lo = 1'b1;
				state_nx   = ST_MHI;
			end
			ST_MHI: begin
				cmd.mul_hi = 1'b1;
				state_nx   = ST_MD;
			end
			ST_MD: begin
				cmd.mul_d = 1'b1;
				state_nx  = ST_MB;
			end
			ST_MB: begin
				cmd.mul_b = 1'b1;
				state_nx  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum  = 1'b1;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				// hold until the result register is free
				if (out_free) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

/* rtl/core/motor_speed_pi_regulator_unit.sv */
// ----------------------------------------------------------------------------
// motor_speed_pi_regulator_unit
// Discrete PI speed regulator for one motor. Each input word carries an
// encoder capture period (s_tdata) and a running flag (s_tuser); each output
// word carries the clamped PWM duty, the measured speed byte and the signed
// speed error. After acceptance an item first passes the bit-serial divider
// that turns the capture period into a speed, then the error step and
// sequential passes through one shared 26x24 multiplier and the PI sums. A
// new word is accepted in the cycle after the previous result is registered,
// so the unit takes no new word before it is through with the last one; a
// finished result may wait in the output register while the next word is
// being worked. Gains are written through the cfg port, by register index;
// the user must write them only while the unit is idle, which it does not enforce.
// ----------------------------------------------------------------------------
`include "motor_speed_pi_regulator_unit_assert.svh"

module motor_speed_pi_regulator_unit import mspi_pkg::*; #(
	parameter int DUTY_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // [15:0] capture_period
	input  logic                  s_tuser,   // [0] running
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // [15:0] duty, [23:16] measured_speed,
	                                         // [31:24] speed_error
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	mspi_cfg_wr_t cfg_wr;
	mspi_cmd_t    cmd;
	mspi_stat_t   stat;
	logic [15:0]  duty;
	logic [7:0]   measured_speed;
	logic [7:0]   speed_error;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	mspi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mspi_datapath #(
		.DUTY_WIDTH (DUTY_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr         (cfg_wr),
		.cmd            (cmd),
		.stat           (stat),
		.capture_period (s_tdata),
		.running        (s_tuser),
		.duty           (duty),
		.measured_speed (measured_speed),
		.speed_error    (speed_error)
	);

	assign m_tdata = {speed_error, measured_speed, duty};

	// one phase command at a time
	`MSPI_ASSERT_IMPLY(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0(cmd))
	// a result is never written over one that has not been taken
	`MSPI_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, cmd.finish, !m_tvalid || m_tready)
	// busy right after accepting a word
	`MSPI_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule
